FILE: rtl/kn_angle_rejection_trial_defines.svh
// assertion helpers for the kn_angle_rejection_trial block
`ifndef KN_ANGLE_REJECTION_TRIAL_DEFINES_SVH
`define KN_ANGLE_REJECTION_TRIAL_DEFINES_SVH

// checked on every rising edge once reset is released
`define KART_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`endif

FILE: rtl/kart_pkg.sv
// ----------------------------------------------------------------------------
// kart_pkg
// shared constants and the word carried along the divider cell chain
// ----------------------------------------------------------------------------
package kart_pkg;

	localparam int DIV_STEPS = 31;
	localparam int REM_W     = 45;
	localparam int DEN_W     = 44;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef struct packed {
		logic [REM_W-1:0]     rem;
		logic [DEN_W-1:0]     den;
		logic [DIV_STEPS-1:0] quo;
		logic [31:0]          mu;
		logic [30:0]          m2;
		logic [31:0]          u2;
	} kart_div_t;

endpackage

FILE: rtl/kart_div_cell.sv
// ----------------------------------------------------------------------------
// kart_div_cell
// one restoring-division step: one quotient bit per cell, registered
// ----------------------------------------------------------------------------
module kart_div_cell import kart_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_vld,
	input  kart_div_t in_word,
	output logic      out_vld,
	output kart_div_t out_word
);

	logic             vld_q;
	kart_div_t        word_q;
	logic             ge;
	logic [REM_W-1:0] diff;
	logic [REM_W-1:0] rem_next;
	kart_div_t        word_next;

	always_comb begin
		ge        = in_word.rem >= {1'b0, in_word.den};
		diff      = in_word.rem - {1'b0, in_word.den};
		rem_next  = ge ? diff : in_word.rem;
		word_next = in_word;
		// remainder stays below den, so the shift cannot overflow
		word_next.rem = {rem_next[REM_W-2:0], 1'b0};
		word_next.quo = {in_word.quo[DIV_STEPS-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q <= word_next;
		end
	end

	assign out_vld  = vld_q;
	assign out_word = word_q;

endmodule

FILE: rtl/kn_angle_rejection_trial.sv
// One Klein-Nishina rejection trial per word. The pipeline has two input
// stages, a chain of 31 divider cells (one quotient bit of 2^60/D each), three
// kernel arithmetic stages and the output register. A new word is taken every
// cycle; the whole pipeline holds only while a finished word waits downstream.
// ----------------------------------------------------------------------------
// kn_angle_rejection_trial
// cosine proposal, energy ratio, kernel weight and accept/envelope flags
// ----------------------------------------------------------------------------
`include "kn_angle_rejection_trial_defines.svh"

module kn_angle_rejection_trial import kart_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// photon_energy[31:0], proposal_uniform[63:32], accept_uniform[95:64]
	input  logic [95:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// cosine[31:0], energy_ratio[62:32], kernel_weight[93:63],
	// accepted[94], envelope_error[95]
	output logic [95:0] m_axis_tdata
);

	logic en;

	// stage 1: cosine, eps*(1-mu), mu^2
	logic [30:0] half_u1;
	logic [31:0] omm;
	logic [63:0] prod;
	logic [30:0] mu_abs;
	logic [61:0] musq;
	logic        vld_s1;
	logic [62:0] prod_s1;
	logic [30:0] m2_s1;
	logic [31:0] mu_s1;
	logic [31:0] u2_s1;

	assign half_u1 = s_axis_tdata[63:33];
	assign omm     = 32'h8000_0000 - {1'b0, half_u1};
	assign prod    = {32'd0, s_axis_tdata[31:0]} * {32'd0, omm};
	assign mu_abs  = (half_u1 >= Q30_ONE) ? (half_u1 - Q30_ONE) : (Q30_ONE - half_u1);
	assign musq    = {31'd0, mu_abs} * {31'd0, mu_abs};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod[62:0];
			m2_s1   <= musq[60:30];
			mu_s1   <= {1'b0, half_u1} - {1'b0, Q30_ONE};
			u2_s1   <= s_axis_tdata[95:64];
		end
	end

	// stage 2: denominator 1 + eps*(1-mu) in Q30
	logic             vld_s2;
	logic [DEN_W-1:0] den_s2;
	logic [30:0]      m2_s2;
	logic [31:0]      mu_s2;
	logic [31:0]      u2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2 <= {13'd0, Q30_ONE} + {1'b0, prod_s1[62:20]};
			m2_s2  <= m2_s1;
			mu_s2  <= mu_s1;
			u2_s2  <= u2_s1;
		end
	end

	// divider chain
	logic      chain_vld  [DIV_STEPS+1];
	kart_div_t chain_word [DIV_STEPS+1];

	always_comb begin
		chain_vld[0]       = vld_s2;
		chain_word[0].rem  = {{(REM_W-31){1'b0}}, Q30_ONE};
		chain_word[0].den  = den_s2;
		chain_word[0].quo  = '0;
		chain_word[0].mu   = mu_s2;
		chain_word[0].m2   = m2_s2;
		chain_word[0].u2   = u2_s2;
	end

	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
		kart_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (chain_vld[i]),
			.in_word  (chain_word[i]),
			.out_vld  (chain_vld[i+1]),
			.out_word (chain_word[i+1])
		);
	end

	// stage 3: r^2
	logic [30:0] r_div;
	logic [61:0] rsq;
	logic        vld_s3;
	logic [30:0] r_s3;
	logic [30:0] r2_s3;
	logic [30:0] m2_s3;
	logic [31:0] mu_s3;
	logic [31:0] u2_s3;

	assign r_div = chain_word[DIV_STEPS].quo;
	assign rsq   = {31'd0, r_div} * {31'd0, r_div};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= chain_vld[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3  <= r_div;
			r2_s3 <= rsq[60:30];
			m2_s3 <= chain_word[DIV_STEPS].m2;
			mu_s3 <= chain_word[DIV_STEPS].mu;
			u2_s3 <= chain_word[DIV_STEPS].u2;
		end
	end

	// stage 4: r^3 and r^2*(1-mu^2)
	logic [30:0] omm2;
	logic [61:0] rcube;
	logic [61:0] tprod;
	logic        vld_s4;
	logic [30:0] r_s4;
	logic [30:0] r3_s4;
	logic [30:0] t_s4;
	logic [31:0] mu_s4;
	logic [31:0] u2_s4;

	assign omm2  = Q30_ONE - m2_s3;
	assign rcube = {31'd0, r2_s3} * {31'd0, r_s3};
	assign tprod = {31'd0, r2_s3} * {31'd0, omm2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s4  <= r_s3;
			r3_s4 <= rcube[60:30];
			t_s4  <= tprod[60:30];
			mu_s4 <= mu_s3;
			u2_s4 <= u2_s3;
		end
	end

	// stage 5: weight
	logic        vld_s5;
	logic [31:0] w_s5;
	logic [30:0] r_s5;
	logic [31:0] mu_s5;
	logic [31:0] u2_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s5  <= {1'b0, r3_s4} + {1'b0, r_s4} - {1'b0, t_s4};
			r_s5  <= r_s4;
			mu_s5 <= mu_s4;
			u2_s5 <= u2_s4;
		end
	end

	// output register
	logic        out_vld_q;
	logic [31:0] cos_q;
	logic [30:0] ratio_q;
	logic [30:0] weight_q;
	logic        acc_q;
	logic        env_q;
	logic [30:0] w_sat;

	assign w_sat = w_s5[31] ? 31'h7FFF_FFFF : w_s5[30:0];
	assign en    = !out_vld_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q    <= mu_s5;
			ratio_q  <= r_s5;
			weight_q <= w_sat;
			acc_q    <= {1'b0, u2_s5} <= {w_s5, 1'b0};
			env_q    <= w_s5 > 32'h8000_0000;
		end
	end

	assign s_axis_tready = en;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = {env_q, acc_q, weight_q, ratio_q, cos_q};

	`KART_ASSERT(a_ratio_range, out_vld_q |-> (ratio_q <= Q30_ONE), "energy ratio above one")
	`KART_ASSERT(a_no_envelope, out_vld_q |-> !env_q, "kernel weight exceeded envelope")
	`KART_ASSERT(a_hold_out, (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(ratio_q) && $stable(weight_q)), "stalled result changed")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives rejection trials into kn_angle_rejection_trial under random stalls and
// compares every output word field by field against a local fixed-point model
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic [31:0] energy;
		logic [31:0] prop_u;
		logic [31:0] acc_u;
	} trial_t;

	typedef struct packed {
		logic        env_err;
		logic        accepted;
		logic [30:0] weight;
		logic [30:0] ratio;
		logic [31:0] cosine;
	} verdict_t;

	typedef struct {
		trial_t   trial;
		logic     typed;
		verdict_t res;
	} row_t;

	localparam int LATENCY   = 37;
	localparam int WATCH_MAX = 20000;
	localparam int N_RANDOM  = 1300;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [95:0] m_axis_tdata;

	verdict_t verdict_q[$];
	int       mismatches;
	int       idle_in_pct;
	int       idle_out_pct;
	int       quiet_cycles;
	bit       timed_out;

	kn_angle_rejection_trial i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic verdict_t kn_trial_outcome(trial_t tr);
		logic [63:0] half_u, one_minus_mu, mu_abs, prod, den, r, r2, r3, m2, t, w;
		verdict_t v;
		half_u       = {33'd0, tr.prop_u[31:1]};
		one_minus_mu = 64'h8000_0000 - half_u;
		mu_abs       = half_u >= 64'h4000_0000 ? half_u - 64'h4000_0000
		                                       : 64'h4000_0000 - half_u;
		prod         = {32'd0, tr.energy} * one_minus_mu;
		den          = 64'h4000_0000 + (prod >> 20);
		r            = (64'd1 << 60) / den;
		r2           = (r * r) >> 30;
		r3           = (r2 * r) >> 30;
		m2           = (mu_abs * mu_abs) >> 30;
		t            = (r2 * (64'h4000_0000 - m2)) >> 30;
		w            = r3 + r - t;
		v.cosine     = half_u[31:0] - 32'h4000_0000;
		v.ratio      = r[30:0];
		v.weight     = w > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : w[30:0];
		v.accepted   = {32'd0, tr.acc_u} <= 2 * w;
		v.env_err    = w > 64'h8000_0000;
		return v;
	endfunction

	task automatic send_trial(trial_t tr);
		s_axis_tvalid <= 1'b1;
		// photon_energy in the lowest bits
		s_axis_tdata  <= {tr.acc_u, tr.prop_u, tr.energy};
		do @(posedge clk); while (!s_axis_tready);
		verdict_q.push_back(kn_trial_outcome(tr));
		if ($urandom_range(99) < idle_in_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0 && !timed_out) @(posedge clk);
	endtask

	// receiver stalls and output checking
	always @(posedge clk) begin
		verdict_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (verdict_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h", m_axis_tdata);
				end else begin
					want = verdict_q.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: cos %h/%h ratio %h/%h weight %h/%h acc %b/%b env %b/%b (exp/got)",
								want.cosine, got.cosine, want.ratio, got.ratio,
								want.weight, got.weight, want.accepted, got.accepted,
								want.env_err, got.env_err);
					end
				end
			end
			m_axis_tready <= $urandom_range(99) >= idle_out_pct;
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCH_MAX) begin
			timed_out = 1'b1;
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		row_t   rows[$];
		trial_t tr;
		int     phase;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		arst_n        = 1'b0;
		mismatches    = 0;
		quiet_cycles  = 0;
		timed_out     = 1'b0;
		idle_in_pct   = 27;
		idle_out_pct  = 69;

		// eps 0 with mu -1 gives weight exactly two: saturated output, accepted
		rows.push_back('{'{32'd0, 32'd0, 32'hFFFF_FFFF}, 1'b1,
			'{1'b0, 1'b1, 31'h7FFF_FFFF, 31'h4000_0000, 32'hC000_0000}});
		// eps 0 with mu near +1: r one, weight about two
		rows.push_back('{'{32'd0, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0});
		rows.push_back('{'{32'd0, 32'h8000_0000, 32'h8000_0000}, 1'b0, '0});
		// largest energy drives r toward zero unless mu is near +1
		rows.push_back('{'{32'hFFFF_FFFF, 32'd0, 32'd0}, 1'b0, '0});
		rows.push_back('{'{32'hFFFF_FFFF, 32'd0, 32'd1}, 1'b0, '0});
		rows.push_back('{'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0});
		rows.push_back('{'{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h5555_5555}, 1'b0, '0});
		rows.push_back('{'{32'h0010_0000, 32'd0, 32'hFFFF_FFFF}, 1'b0, '0});
		rows.push_back('{'{32'h0010_0000, 32'h4000_0000, 32'h8000_0000}, 1'b0, '0});
		rows.push_back('{'{32'd1, 32'd1, 32'hAAAA_AAAA}, 1'b0, '0});
		rows.push_back('{'{32'h0000_0400, 32'hC000_0000, 32'h2000_0000}, 1'b0, '0});
		rows.push_back('{'{32'h8000_0000, 32'h0000_0002, 32'h0000_0001}, 1'b0, '0});
		rows.push_back('{'{32'h0001_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFE}, 1'b0, '0});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].typed && rows[i].res !== kn_trial_outcome(rows[i].trial)) begin
				mismatches++;
				if (mismatches <= 10)
					$display("typed row %0d: exp %h model %h", i, rows[i].res,
						kn_trial_outcome(rows[i].trial));
			end
			send_trial(rows[i].trial);
		end
		// hold off until the pipe is empty
		drain_results();

		for (phase = 0; phase < 3; phase++) begin
			idle_in_pct  = phase == 0 ? 27 : (phase == 1 ? 69 : 0);
			idle_out_pct = phase == 0 ? 69 : (phase == 1 ? 27 : 0);
			repeat (N_RANDOM / 3) begin
				case ($urandom_range(3))
					0: tr.energy = $urandom;
					1: tr.energy = $urandom_range(32'h0040_0000);
					2: tr.energy = $urandom_range(32'h0000_1000);
					default: tr.energy = $urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF;
				endcase
				tr.prop_u = $urandom_range(7) == 0 ? ($urandom_range(1) ? 32'd0 : 32'hFFFF_FFFF)
				                                   : $urandom;
				tr.acc_u  = $urandom;
				send_trial(tr);
			end
		end

		drain_results();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
